// ===== sv/dss_pkg.sv =====
// Shared constants and types for the drum step sequencer sampler.
`timescale 1ns / 1ps
package dss_pkg;

    localparam int MAX_VOICE_LEN_DEF = 16384;
    localparam int MAX_STEPS_DEF     = 16;
    localparam int SAMPLE_BITS_DEF   = 16;

    localparam int NUM_VOICES = 6;
    localparam int NUM_SLOTS  = 4;

    localparam logic [15:0] GAIN_KICK_SOFT  = 16'd19661;
    localparam logic [15:0] GAIN_SNARE_SOFT = 16'd10486;
    localparam logic [15:0] GAIN_HAT_SOFT   = 16'd18022;

    // Configuration register indexes
    localparam logic [2:0] REG_KICK      = 3'd0;
    localparam logic [2:0] REG_SNARE     = 3'd1;
    localparam logic [2:0] REG_HAT       = 3'd2;
    localparam logic [2:0] REG_MID_MASK  = 3'd3;
    localparam logic [2:0] REG_SPB       = 3'd4;
    localparam logic [2:0] REG_BEAT      = 3'd5;
    localparam logic [2:0] REG_VOLUME    = 3'd6;
    localparam logic [2:0] REG_MUTED     = 3'd7;

    // Click voice selects
    localparam logic [1:0] CLICK_PRIMARY   = 2'd0;
    localparam logic [1:0] CLICK_SECONDARY = 2'd1;
    localparam logic [1:0] CLICK_PLAIN     = 2'd2;

    // Requests to the divider
    typedef struct packed {
        logic        start;
        logic [24:0] dividend;
        logic [19:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [24:0] quotient;
    } div_rsp_t;

endpackage

// ===== sv/drum_step_sequencer_sampler.sv =====
// Top level of the drum step sequencer sampler.
//
// Usage: items enter on in_valid/in_ready. A load item (action 1) writes one
// waveform word and gives no result. A tick item (action 0) computes the grid
// step with a bit-serial divider, fires clicks and drums, mixes the four
// playback slots by reading the wave memory one slot at a time through one
// shared multiplier, and gives one result on out_valid/out_ready.
// A valid load goes through a write state; a load to a bad voice or index is
// dropped at acceptance. A tick runs the divider, a trigger step, then per slot
// either address and accumulate (idle slot) or address, read wait, gain
// multiply and accumulate (playing slot), then volume, saturation and output.
// A tick with a zero bar length skips the divider and trigger. One item is
// in work at a time; in_ready is low while busy and while a result waits in
// the output register. After reset all voices are silent (length zero), no
// step has been seen, and registers hold their reset values. Configuration
// writes via cfg_we, cfg_index, cfg_data take effect at once; the user must
// make them only while idle, as the block does not enforce it. A stalled
// receiver holds the result; the next item waits until it is taken.
`timescale 1ns / 1ps
module drum_step_sequencer_sampler #(
    parameter int MAX_VOICE_LEN = dss_pkg::MAX_VOICE_LEN_DEF,
    parameter int MAX_STEPS     = dss_pkg::MAX_STEPS_DEF,
    parameter int SAMPLE_BITS   = dss_pkg::SAMPLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   action,
    input  logic [19:0]            phase_frames,
    input  logic [19:0]            frames_per_bar,
    input  logic                   clicks_on,
    input  logic                   drums_on,
    input  logic [2:0]             voice,
    input  logic [13:0]            sample_index,
    input  logic signed [15:0]     sample_value,
    input  logic                   sample_last,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    output logic [3:0]             current_step,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [31:0]            cfg_data
);
    import dss_pkg::*;

    localparam int PW     = $clog2(MAX_VOICE_LEN);
    localparam int LW     = PW + 1;
    localparam int AW     = $clog2(NUM_VOICES * MAX_VOICE_LEN);
    localparam int SW     = $clog2(MAX_STEPS) + 1;
    localparam logic [SW-1:0] MAX_STEPS_C = SW'(MAX_STEPS);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_DIV, S_TRIG, S_READ, S_WAIT, S_MUL, S_ACC,
        S_VOL, S_VRND, S_OUT
    } state_t;

    // Configuration registers
    logic [31:0] kick_reg, snare_reg, hat_reg;
    logic [15:0] mid_reg, volume_reg;
    logic [4:0]  spb_reg, beat_reg;
    logic        muted_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kick_reg   <= 32'd16843009;
            snare_reg  <= 32'd269488144;
            hat_reg    <= 32'd286348629;
            mid_reg    <= '0;
            spb_reg    <= 5'd16;
            beat_reg   <= 5'd4;
            volume_reg <= 16'd32768;
            muted_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KICK:     kick_reg   <= cfg_data;
                REG_SNARE:    snare_reg  <= cfg_data;
                REG_HAT:      hat_reg    <= cfg_data;
                REG_MID_MASK: mid_reg    <= cfg_data[15:0];
                REG_SPB:      spb_reg    <= cfg_data[4:0];
                REG_BEAT:     beat_reg   <= cfg_data[4:0];
                REG_VOLUME:   volume_reg <= cfg_data[15:0];
                REG_MUTED:    muted_reg  <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // Sequencer state
    state_t            state_reg;
    logic [LW-1:0]     len_reg   [NUM_VOICES];
    logic [PW-1:0]     pos_reg   [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] act_reg;
    logic [1:0]        csel_reg;
    logic [2:0]        soft_reg;
    logic [SW-1:0]     pstep_reg;
    logic              pvalid_reg;
    logic [SW-1:0]     pgrid_reg;
    logic [1:0]        slot_reg;
    logic signed [24:0] sum_reg;
    logic signed [41:0] prod_reg;
    logic [SW-1:0]     step_reg;
    logic              clk_en_reg, drm_en_reg;
    logic              out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic [3:0]        out_step_reg;
    logic [2:0]        lvoice_reg;
    logic [13:0]       lidx_reg;
    logic [15:0]       lval_reg;
    logic              llast_reg;

    // Clamp the grid registers
    logic [SW-1:0] spb_c;
    logic [4:0]    beat_c;
    always_comb
    begin
        if (spb_reg == 5'd0)
            spb_c = SW'(1);
        else if ({1'b0, spb_reg} > 6'(MAX_STEPS))
            spb_c = MAX_STEPS_C;
        else
            spb_c = SW'(spb_reg);
        beat_c = (beat_reg == 5'd0) ? 5'd1 : ((beat_reg > 5'd16) ? 5'd16 : beat_reg);
    end

    // Divider
    div_req_t div_req;
    div_rsp_t div_rsp;
    dss_divider u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

    assign div_req.start    = (state_reg == S_IDLE) && in_valid && in_ready && !action
                              && (frames_per_bar != 20'd0);
    assign div_req.dividend = 25'(phase_frames) * 25'(spb_c);
    assign div_req.divisor  = frames_per_bar;

    // Wave memory
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [15:0]   mem_rdata;
    logic [2:0]    slot_voice;
    always_comb
    begin
        case (slot_reg)
            2'd0:    slot_voice = (csel_reg > 2'd2) ? 3'd2 : {1'b0, csel_reg};
            2'd1:    slot_voice = 3'd3;
            2'd2:    slot_voice = 3'd4;
            default: slot_voice = 3'd5;
        endcase
    end
    assign mem_we   = (state_reg == S_LOAD);
    assign mem_addr = mem_we
        ? AW'(AW'(lvoice_reg) * AW'(MAX_VOICE_LEN) + AW'(lidx_reg))
        : AW'(AW'(slot_voice) * AW'(MAX_VOICE_LEN) + AW'(pos_reg[slot_reg]));
    dss_wave_mem #(.DEPTH(NUM_VOICES * MAX_VOICE_LEN), .AW(AW), .DW(16)) u_mem (
        .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(lval_reg), .rdata(mem_rdata)
    );

    // Slot gain and playability
    logic [15:0] gain;
    logic        gain_full;
    logic [LW-1:0] slen;
    logic        playable;
    always_comb
    begin
        case (slot_reg)
            2'd1:    gain = GAIN_KICK_SOFT;
            2'd2:    gain = GAIN_SNARE_SOFT;
            default: gain = GAIN_HAT_SOFT;
        endcase
        gain_full = (slot_reg == 2'd0) || !soft_reg[slot_reg - 2'd1];
        slen      = len_reg[slot_voice];
        playable  = act_reg[slot_reg] && ({1'b0, pos_reg[slot_reg]} < slen);
    end

    // Shared multiplier operands
    logic signed [16:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [41:0] mul_p;
    always_comb
    begin
        if (state_reg == S_VOL)
        begin
            mul_a = $signed({1'b0, volume_reg});
            mul_b = sum_reg;
        end
        else
        begin
            mul_a = $signed({1'b0, gain});
            mul_b = 25'(signed'(mem_rdata));
        end
        mul_p = 42'(mul_a) * 42'(mul_b);
    end

    // Rounding half up after a 15-bit shift: floor((v + 16384) / 32768)
    logic signed [41:0] rnd_src;
    logic signed [41:0] rnd_res;
    always_comb
    begin
        rnd_src = prod_reg + 42'sd16384;
        rnd_res = rnd_src >>> 15;
    end

    logic [SW-1:0] step_c;
    logic [15:0]   step_bit;
    logic          click_hit;
    assign step_c   = (div_rsp.quotient > 25'(spb_c - SW'(1))) ? (spb_c - SW'(1))
                                                                : SW'(div_rsp.quotient);
    assign step_bit = (step_reg < SW'(16)) ? (16'd1 << step_reg[3:0]) : 16'd0;

    // Match the step against every multiple of the beat length
    always_comb
    begin
        click_hit = 1'b0;
        for (int k = 0; k < MAX_STEPS; k++)
        begin
            if (12'(k) * 12'(beat_c) == 12'(step_reg))
                click_hit = 1'b1;
        end
    end

    logic signed [SAMPLE_BITS-1:0] sat_val;
    always_comb
    begin
        if (rnd_res > 42'((1 << (SAMPLE_BITS - 1)) - 1))
            sat_val = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        else if (rnd_res < -42'(1 << (SAMPLE_BITS - 1)))
            sat_val = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            sat_val = SAMPLE_BITS'(rnd_res);
    end

    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;

    // Main sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            for (int i = 0; i < NUM_VOICES; i++)
                len_reg[i] <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
                pos_reg[i] <= '0;
            act_reg       <= '0;
            csel_reg      <= CLICK_PLAIN;
            soft_reg      <= '0;
            pstep_reg     <= '0;
            pvalid_reg    <= 1'b0;
            pgrid_reg     <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        lvoice_reg   <= voice;
                        lidx_reg     <= sample_index;
                        lval_reg     <= sample_value;
                        llast_reg    <= sample_last;
                        clk_en_reg   <= clicks_on;
                        drm_en_reg   <= drums_on;
                        if (action)
                        begin
                            if (voice < 3'(NUM_VOICES)
                                && {1'b0, sample_index} < 15'(MAX_VOICE_LEN))
                                state_reg <= S_LOAD;
                        end
                        else if (frames_per_bar == 20'd0)
                        begin
                            step_reg  <= '0;
                            sum_reg   <= '0;
                            slot_reg  <= '0;
                            state_reg <= S_READ;
                        end
                        else
                            state_reg <= S_DIV;
                    end
                end
                S_LOAD:
                begin
                    if (llast_reg)
                        len_reg[lvoice_reg] <= LW'(lidx_reg) + LW'(1);
                    state_reg <= S_IDLE;
                end
                S_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        step_reg  <= step_c;
                        state_reg <= S_TRIG;
                    end
                end
                S_TRIG:
                begin
                    sum_reg   <= '0;
                    slot_reg  <= '0;
                    state_reg <= S_READ;
                    // Adopt a new grid without firing, or fire a new step
                    if (spb_c != pgrid_reg && pvalid_reg)
                    begin
                        pgrid_reg <= spb_c;
                        pstep_reg <= step_reg;
                    end
                    else if (!(pvalid_reg && step_reg == pstep_reg))
                    begin
                        pgrid_reg  <= spb_c;
                        pstep_reg  <= step_reg;
                        pvalid_reg <= 1'b1;
                        if (clk_en_reg && click_hit)
                        begin
                            csel_reg <= (step_reg == '0) ? CLICK_PRIMARY
                                      : ((mid_reg & step_bit) != 16'd0) ? CLICK_SECONDARY
                                      : CLICK_PLAIN;
                            act_reg[0] <= 1'b1;
                            pos_reg[0] <= '0;
                        end
                        if (drm_en_reg && !muted_reg)
                        begin
                            if ((kick_reg[15:0] & step_bit) != 16'd0)
                            begin
                                act_reg[1]  <= 1'b1;
                                pos_reg[1]  <= '0;
                                soft_reg[0] <= (kick_reg[31:16] & step_bit) == 16'd0;
                            end
                            if ((snare_reg[15:0] & step_bit) != 16'd0)
                            begin
                                act_reg[2]  <= 1'b1;
                                pos_reg[2]  <= '0;
                                soft_reg[1] <= (snare_reg[31:16] & step_bit) == 16'd0;
                            end
                            if ((hat_reg[15:0] & step_bit) != 16'd0)
                            begin
                                act_reg[3]  <= 1'b1;
                                pos_reg[3]  <= '0;
                                soft_reg[2] <= (hat_reg[31:16] & step_bit) == 16'd0;
                            end
                        end
                    end
                    else
                        pgrid_reg <= spb_c;
                end
                S_READ:
                begin
                    // Memory address is presented this cycle
                    if (playable)
                        state_reg <= S_WAIT;
                    else
                    begin
                        act_reg[slot_reg] <= 1'b0;
                        prod_reg  <= '0;
                        state_reg <= S_ACC;
                    end
                end
                S_WAIT:
                begin
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    if (gain_full)
                        prod_reg <= 42'(signed'(mem_rdata)) <<< 15;
                    else
                        prod_reg <= mul_p;
                    pos_reg[slot_reg] <= pos_reg[slot_reg] + PW'(1);
                    if ({1'b0, pos_reg[slot_reg]} + LW'(1) >= slen)
                        act_reg[slot_reg] <= 1'b0;
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    sum_reg <= sum_reg + 25'(rnd_res);
                    if (slot_reg == 2'd3)
                        state_reg <= S_VOL;
                    else
                    begin
                        slot_reg  <= slot_reg + 2'd1;
                        state_reg <= S_READ;
                    end
                end
                S_VOL:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_VRND;
                end
                S_VRND:
                begin
                    out_sample_reg <= sat_val;
                    out_step_reg   <= 4'(step_reg);
                    state_reg      <= S_OUT;
                end
                S_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample_out   = out_sample_reg;
    assign current_step = out_step_reg;

    // A tick with a zero bar length does not start the divider
    assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> (frames_per_bar != 20'd0))
        else $error("divider started with zero divisor");

    // No new item is taken while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !in_ready)
        else $error("input taken while result pending");

    // Divider completes only during the division state
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV))
        else $error("divider done outside division");

endmodule

// ===== sv/dss_divider.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module dss_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  dss_pkg::div_req_t req,
    output dss_pkg::div_rsp_t rsp
);
    import dss_pkg::*;

    logic [24:0] quot_reg, quot_next;
    logic [20:0] rem_reg, rem_next;
    logic [19:0] dvs_reg, dvs_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [20:0] trial;

    // Load a new request, or shift one dividend bit into the remainder and try the subtract
    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[19:0], quot_reg[24]};
        if (req.start)
        begin
            quot_next = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = 5'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next  = trial - {1'b0, dvs_reg};
                quot_next = {quot_reg[23:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[23:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd24)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule

// ===== sv/dss_wave_mem.sv =====
// Voice waveform memory, one address port shared by write and read, registered read.
`timescale 1ns / 1ps
module dss_wave_mem #(
    parameter int DEPTH = 98304,
    parameter int AW    = 17,
    parameter int DW    = 16
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [DEPTH];

    // Write the addressed word when enabled; always read it (old data on a write)
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end

endmodule

// ===== verif/tb_drum_step_sequencer_sampler.sv =====
// Testbench for the drum step sequencer sampler: directed and random traffic with a built-in predictor.
`timescale 1ns / 1ps
module tb_drum_step_sequencer_sampler;
    import dss_pkg::*;

    localparam bit ACT_TICK = 1'b0;
    localparam bit ACT_LOAD = 1'b1;
    localparam int VOICE_LEN = 16384;
    localparam int SLOT_CLICK = 0;
    localparam int SLOT_KICK = 1;
    localparam int SLOT_SNARE = 2;
    localparam int SLOT_HAT = 3;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct {
        bit        act;
        bit [19:0] phase;
        bit [19:0] fpb;
        bit        clicks;
        bit        drums;
        bit [2:0]  vsel;
        bit [13:0] idx;
        bit [15:0] val;
        bit        last;
    } frame_req_t;

    typedef struct {
        bit [15:0] sample;
        bit [3:0]  step;
    } mix_out_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        action;
    logic [19:0] phase_frames;
    logic [19:0] frames_per_bar;
    logic        clicks_on;
    logic        drums_on;
    logic [2:0]  voice;
    logic [13:0] sample_index;
    logic signed [15:0] sample_value;
    logic        sample_last;
    logic        out_valid;
    logic        out_ready;
    logic signed [15:0] sample_out;
    logic [3:0]  current_step;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    drum_step_sequencer_sampler uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .phase_frames(phase_frames), .frames_per_bar(frames_per_bar),
        .clicks_on(clicks_on), .drums_on(drums_on), .voice(voice),
        .sample_index(sample_index), .sample_value(sample_value), .sample_last(sample_last),
        .out_valid(out_valid), .out_ready(out_ready),
        .sample_out(sample_out), .current_step(current_step),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Pending requests, expected mixes, error count
    frame_req_t pend_q[$];
    mix_out_t   mix_q[$];
    int         errors;

    // Predictor copy of registers and state
    bit [31:0] m_kick, m_snare, m_hat;
    bit [15:0] m_mid_mask, m_volume;
    bit [4:0]  m_spb, m_beat;
    bit        m_muted;
    bit [15:0] m_wave [0:NUM_VOICES*VOICE_LEN-1];
    int        m_len [NUM_VOICES];
    int        m_pos [NUM_SLOTS];
    bit        m_act [NUM_SLOTS];
    bit [1:0]  m_click;
    bit        m_soft [3];
    int        m_prev_step;
    bit        m_prev_ok;
    int        m_prev_grid;

    // Generator bookkeeping: contiguous written prefix per voice
    bit        g_written [NUM_VOICES][VOICE_LEN];
    int        g_prefix [NUM_VOICES];

    // Flow control state
    frame_req_t held;
    bit         fire;
    int         burst_left;
    int         gap_left;
    int         hold_left;
    bit         long_hold_req;
    bit         hold_done;
    int         rdy_cyc;
    int         idle_cyc;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    task automatic report(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic longint round15(input longint v);
        return (v + 16384) >>> 15;
    endfunction

    // Play one slot for one frame and advance it
    function automatic longint play_slot(input int slot, input int v, input int gain);
        longint s;
        int p;
        if (!m_act[slot])
            return 0;
        p = m_pos[slot];
        if (p >= m_len[v] || p >= VOICE_LEN) begin
            m_act[slot] = 1'b0;
            return 0;
        end
        s = longint'($signed(m_wave[v*VOICE_LEN + p]));
        p++;
        m_pos[slot] = p;
        if (p >= m_len[v])
            m_act[slot] = 1'b0;
        if (gain == 0)
            return s;
        return round15(s * gain);
    endfunction

    function automatic void start_drum(input int slot, input bit [31:0] pat, input int st);
        if (st < 16 && pat[st]) begin
            m_act[slot] = 1'b1;
            m_pos[slot] = 0;
            m_soft[slot-1] = !pat[16+st];
        end
    endfunction

    // Apply a load, or work out the step, fire voices and mix one frame
    task automatic model_accept(input frame_req_t r);
        int spb, beat, st;
        bit fire_step;
        longint sum, mixed;
        int vc;
        mix_out_t o;
        if (r.act == ACT_LOAD) begin
            if (r.vsel < NUM_VOICES) begin
                m_wave[r.vsel*VOICE_LEN + r.idx] = r.val;
                if (r.last)
                    m_len[r.vsel] = r.idx + 1;
            end
            return;
        end
        spb = (m_spb < 1) ? 1 : (m_spb > 16 ? 16 : m_spb);
        beat = (m_beat < 1) ? 1 : (m_beat > 16 ? 16 : m_beat);
        st = 0;
        fire_step = 1'b0;
        if (r.fpb != 0) begin
            st = int'((longint'(r.phase) * spb) / r.fpb);
            if (st > spb - 1)
                st = spb - 1;
            fire_step = 1'b1;
            if (spb != m_prev_grid) begin
                m_prev_grid = spb;
                if (m_prev_ok) begin
                    m_prev_step = st;
                    fire_step = 1'b0;
                end
            end
            if (fire_step && m_prev_ok && st == m_prev_step)
                fire_step = 1'b0;
        end
        if (fire_step) begin
            m_prev_step = st;
            m_prev_ok = 1'b1;
            if (r.clicks && (st % beat) == 0) begin
                if (st == 0)
                    m_click = CLICK_PRIMARY;
                else if (st < 16 && m_mid_mask[st])
                    m_click = CLICK_SECONDARY;
                else
                    m_click = CLICK_PLAIN;
                m_act[SLOT_CLICK] = 1'b1;
                m_pos[SLOT_CLICK] = 0;
            end
            if (r.drums && !m_muted) begin
                start_drum(SLOT_KICK, m_kick, st);
                start_drum(SLOT_SNARE, m_snare, st);
                start_drum(SLOT_HAT, m_hat, st);
            end
        end
        vc = (m_click > CLICK_PLAIN) ? CLICK_PLAIN : m_click;
        sum = play_slot(SLOT_CLICK, vc, 0);
        sum += play_slot(SLOT_KICK, 3, m_soft[0] ? GAIN_KICK_SOFT : 0);
        sum += play_slot(SLOT_SNARE, 4, m_soft[1] ? GAIN_SNARE_SOFT : 0);
        sum += play_slot(SLOT_HAT, 5, m_soft[2] ? GAIN_HAT_SOFT : 0);
        mixed = round15(sum * m_volume);
        if (mixed > 32767)
            mixed = 32767;
        if (mixed < -32768)
            mixed = -32768;
        o.sample = mixed[15:0];
        o.step = st[3:0];
        mix_q.push_back(o);
    endtask

    // Queue a tick request
    task automatic push_tick(input bit [19:0] ph, input bit [19:0] fpb, input bit c,
                             input bit d);
        frame_req_t r;
        r = '{default: '0};
        r.act = ACT_TICK;
        r.phase = ph;
        r.fpb = fpb;
        r.clicks = c;
        r.drums = d;
        r.vsel = 3'($urandom_range(0, 7));
        r.idx = 14'($urandom);
        r.val = 16'($urandom);
        r.last = 1'($urandom);
        pend_q.push_back(r);
    endtask

    // Queue a load request; a length is only set over a fully written waveform
    task automatic push_load(input int v, input int idx, input bit [15:0] val,
                             input bit last);
        frame_req_t r;
        r = '{default: '0};
        r.act = ACT_LOAD;
        r.vsel = 3'(v);
        r.idx = 14'(idx);
        r.val = val;
        r.phase = 20'($urandom);
        r.fpb = 20'($urandom);
        r.clicks = 1'($urandom);
        r.drums = 1'($urandom);
        if (v < NUM_VOICES) begin
            g_written[v][idx] = 1'b1;
            while (g_prefix[v] < VOICE_LEN && g_written[v][g_prefix[v]])
                g_prefix[v]++;
            if (idx >= g_prefix[v])
                last = 1'b0;
        end
        r.last = last;
        pend_q.push_back(r);
    endtask

    // Write one register in the block and the predictor
    task automatic reg_write(input logic [2:0] idx, input bit [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_KICK:     m_kick = val;
            REG_SNARE:    m_snare = val;
            REG_HAT:      m_hat = val;
            REG_MID_MASK: m_mid_mask = val[15:0];
            REG_SPB:      m_spb = val[4:0];
            REG_BEAT:     m_beat = val[4:0];
            REG_VOLUME:   m_volume = val[15:0];
            default:      m_muted = val[0];
        endcase
    endtask

    // Hold until the block has gone quiet
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pend_q.size() != 0 || in_valid || mix_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Random traffic: mostly bars with advancing phase, some loads and noise
    task automatic gen_random(input int count);
        int bar_fpb, ph, n, v, k;
        bar_fpb = $urandom_range(16, 400);
        ph = 0;
        for (n = 0; n < count; n++) begin
            k = $urandom_range(0, 99);
            if (k < 22) begin
                v = $urandom_range(0, 5);
                if (g_prefix[v] < 48)
                    push_load(v, g_prefix[v], 16'($urandom), $urandom_range(0, 2) == 0);
                else
                    push_load(v, $urandom_range(0, 47), 16'($urandom),
                              $urandom_range(0, 5) == 0);
            end else if (k < 27) begin
                push_load($urandom_range(0, 7), $urandom_range(0, VOICE_LEN - 1),
                          16'($urandom), 1'b0);
            end else if (k < 35) begin
                push_tick(20'($urandom), ($urandom_range(0, 9) == 0) ? 20'd0 : 20'($urandom),
                          1'($urandom), 1'($urandom));
            end else begin
                push_tick(20'(ph), 20'(bar_fpb), $urandom_range(0, 5) != 0,
                          $urandom_range(0, 5) != 0);
                ph += $urandom_range(0, bar_fpb / 6 + 1);
                if (ph >= bar_fpb) begin
                    ph = 0;
                    bar_fpb = $urandom_range(16, 400);
                end
            end
        end
    endtask

    // Request driver: bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action <= ACT_TICK;
            phase_frames <= '0;
            frames_per_bar <= '0;
            clicks_on <= 1'b0;
            drums_on <= 1'b0;
            voice <= '0;
            sample_index <= '0;
            sample_value <= '0;
            sample_last <= 1'b0;
            burst_left <= 4;
            gap_left <= 0;
        end
        else
        begin
            fire = in_valid && in_ready;
            if (fire)
            begin
                model_accept(held);
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                    burst_left <= burst_left - 1;
            end
            if (!in_valid || fire)
            begin
                if (pend_q.size() != 0 && (fire ? burst_left > 1 : gap_left == 0))
                begin
                    held = pend_q.pop_front();
                    in_valid <= 1'b1;
                    action <= held.act;
                    phase_frames <= held.phase;
                    frames_per_bar <= held.fpb;
                    clicks_on <= held.clicks;
                    drums_on <= held.drums;
                    voice <= held.vsel;
                    sample_index <= held.idx;
                    sample_value <= held.val;
                    sample_last <= held.last;
                end
                else if (fire)
                    in_valid <= 1'b0;
                else if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
        end
    end

    // Result side: stall pattern, one long hold on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
            rdy_cyc <= 0;
        end
        else
        begin
            rdy_cyc <= rdy_cyc + 1;
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (long_hold_req && !hold_done)
            begin
                out_ready <= 1'b0;
                hold_left <= 600;
                hold_done <= 1'b1;
            end
            else
            begin
                case (rdy_cyc[9:7])
                    3'd0, 3'd1: out_ready <= 1'b1;
                    3'd2:       out_ready <= $urandom_range(0, 1);
                    3'd3:       out_ready <= $urandom_range(0, 3) == 0;
                    default:    out_ready <= $urandom_range(0, 4) != 0;
                endcase
            end
        end
    end

    // Compare each result with the oldest expected mix
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (mix_q.size() == 0)
                report("result with nothing expected");
            else
            begin
                mix_out_t e;
                e = mix_q.pop_front();
                if (sample_out !== e.sample)
                    report($sformatf("sample_out %h, expected %h", sample_out, e.sample));
                if (current_step !== e.step)
                    report($sformatf("current_step %0d, expected %0d", current_step, e.step));
            end
        end
    end

    // Watchdog on cycles without progress
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            idle_cyc <= 0;
        else
        begin
            idle_cyc <= idle_cyc + 1;
            if (idle_cyc == IDLE_LIMIT)
            begin
                $display("watchdog expired, %0d results outstanding", mix_q.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Stimulus and phase control
    initial
    begin
        int ph_i, v, i;
        errors = 0;
        long_hold_req = 1'b0;
        idle_cyc = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_KICK;
        cfg_data = '0;
        m_kick = 32'd16843009;
        m_snare = 32'd269488144;
        m_hat = 32'd286348629;
        m_mid_mask = '0;
        m_spb = 5'd16;
        m_beat = 5'd4;
        m_volume = 16'd32768;
        m_muted = 1'b0;
        for (i = 0; i < NUM_VOICES; i++)
        begin
            m_len[i] = 0;
            g_prefix[i] = 0;
        end
        for (i = 0; i < NUM_SLOTS; i++)
        begin
            m_pos[i] = 0;
            m_act[i] = 1'b0;
        end
        m_soft = '{default: 1'b0};
        m_click = CLICK_PLAIN;
        m_prev_step = 0;
        m_prev_ok = 1'b0;
        m_prev_grid = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: accents, full-scale samples, step edge cases
        reg_write(REG_MID_MASK, 32'h0000_0100);
        reg_write(REG_VOLUME, 32'd32768);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        for (v = 0; v < NUM_VOICES; v++)
        begin
            push_load(v, 0, 16'h7FFF, 1'b0);
            push_load(v, 1, 16'h8000, 1'b1);
        end
        push_load(6, 5, 16'h1234, 1'b1);
        push_load(7, 16383, 16'hFFFF, 1'b1);
        push_load(0, 16383, 16'h5555, 1'b0);
        push_tick(20'd5, 20'd0, 1'b1, 1'b1);
        push_tick(20'd0, 20'd16, 1'b1, 1'b1);
        push_tick(20'd0, 20'd16, 1'b1, 1'b1);
        push_tick(20'd4, 20'd16, 1'b1, 1'b1);
        push_tick(20'd8, 20'd16, 1'b1, 1'b1);
        push_tick(20'd9, 20'd16, 1'b1, 1'b0);
        push_tick(20'hFFFFF, 20'd16, 1'b1, 1'b1);
        push_tick(20'hFFFFF, 20'hFFFFF, 1'b0, 1'b1);
        push_tick(20'd0, 20'hFFFFF, 1'b1, 1'b1);
        wait_idle();

        // Phases over register settings, extremes first
        for (ph_i = 0; ph_i < 6; ph_i++)
        begin
            case (ph_i)
                0:
                begin
                    reg_write(REG_KICK, 32'hFFFF_FFFF);
                    reg_write(REG_SNARE, 32'h0000_FFFF);
                    reg_write(REG_HAT, 32'hFFFF_0000);
                    reg_write(REG_MID_MASK, 32'h0000_FFFF);
                    reg_write(REG_SPB, 32'd31);
                    reg_write(REG_BEAT, 32'd0);
                    reg_write(REG_VOLUME, 32'd65535);
                    reg_write(REG_MUTED, 32'd0);
                end
                1:
                begin
                    reg_write(REG_KICK, 32'd0);
                    reg_write(REG_SPB, 32'd1);
                    reg_write(REG_BEAT, 32'd31);
                    reg_write(REG_VOLUME, 32'd0);
                    reg_write(REG_MUTED, 32'd1);
                end
                2:
                begin
                    reg_write(REG_SPB, 32'd0);
                    reg_write(REG_BEAT, 32'd1);
                    reg_write(REG_VOLUME, 32'd32768);
                    reg_write(REG_MUTED, 32'd0);
                end
                default:
                begin
                    reg_write(REG_KICK, $urandom);
                    reg_write(REG_SNARE, $urandom);
                    reg_write(REG_HAT, $urandom);
                    reg_write(REG_MID_MASK, $urandom);
                    reg_write(REG_SPB, $urandom_range(1, 16));
                    reg_write(REG_BEAT, $urandom_range(0, 31));
                    reg_write(REG_VOLUME, $urandom_range(0, 40000));
                    reg_write(REG_MUTED, $urandom_range(0, 3) == 0);
                end
            endcase
            @(posedge clk);
            cfg_we <= 1'b0;
            @(negedge clk);
            gen_random(240);
            // Long receiver hold while requests keep coming
            if (ph_i == 3)
                long_hold_req = 1'b1;
            wait_idle();
        end

        if (mix_q.size() != 0)
            report($sformatf("%0d results never arrived", mix_q.size()));
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/dss_pkg.sv
sv/dss_divider.sv
sv/dss_wave_mem.sv
sv/drum_step_sequencer_sampler.sv
verif/tb_drum_step_sequencer_sampler.sv
